>>> hw/rtl/csvd_pkg.sv
// ----------------------------------------------------------------------------
// csvd_pkg
// Types and constants shared by the csv field delimiter and its channels.
// ----------------------------------------------------------------------------
package csvd_pkg;

  // character codes with fixed meaning
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // counter limits
  localparam logic [9:0]  FIELD_MAX = 10'd1023;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // configuration channel widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VALUE_SEP_A      = 3'd0,
    CFG_VALUE_SEP_B      = 3'd1,
    CFG_LINE_SEP_A       = 3'd2,
    CFG_LINE_SEP_B       = 3'd3,
    CFG_CRLF_ENABLE      = 3'd4,
    CFG_MAX_QUOTED_LINES = 3'd5
  } cfg_reg_t;

  // classification of a byte
  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_VALUE_SEP = 2'd1,
    KIND_LINE_SEP  = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  // latched error codes
  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_QUOTED_LINES = 2'd1,
    ERR_UNTERMINATED = 2'd2
  } err_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [31:0] byte_offset;
    logic [9:0]  field_number;
    logic [31:0] record_number;
    err_t        error_code;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/csvd_if.sv
// ----------------------------------------------------------------------------
// csvd channel interfaces
// Valid/ready channels for text bytes, classified results and register writes.
// ----------------------------------------------------------------------------

// text byte channel
interface csvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

// classified result channel
interface csvd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] byte_offset;
  logic [9:0]  field_number;
  logic [31:0] record_number;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output out_byte, output byte_offset,
                  output field_number, output record_number, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input byte_offset,
                  input field_number, input record_number, input error_code,
                  input last, output ready);
endinterface

// register write channel
interface csvd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [csvd_pkg::CFG_INDEX_W-1:0] index;
  logic [csvd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/csv_field_delimiter.sv
// ----------------------------------------------------------------------------
// csv_field_delimiter
// Classifies csv text bytes as content, value separator, line separator or
// error, tracking byte offset, field number and record number.
// ----------------------------------------------------------------------------
//
//  channel  role   transfer carries
//  -------  -----  ---------------------------------------------------------
//  text     sink   in_byte, end_of_data
//  tokens   source kind, out_byte, byte_offset, field_number, record_number,
//                  error_code, last
//  cfg      sink   index, data (register write, always ready)
//
// A byte is classified in the cycle it is taken; its zero, one or two
// results land in a four-entry result queue and the first one is visible
// the next cycle. One byte per cycle is sustained while each byte gives one
// result and tokens ready stays high; text ready drops while fewer than two
// queue slots are free, so bytes that replay a held CR can hold the text
// channel. Reset (rst, synchronous) empties the queue, clears text state
// and errors and loads the register defaults.
// ----------------------------------------------------------------------------
module csv_field_delimiter (
  input  logic           clk,
  input  logic           rst,
  csvd_in_if.sink        text,
  csvd_out_if.source     tokens,
  csvd_cfg_if.sink       cfg
);

  // configuration registers
  logic [7:0] value_sep_a, value_sep_b, line_sep_a, line_sep_b;
  logic       crlf_enable;
  logic [7:0] max_quoted_lines;

  // text state
  logic          quote_open, quote_is_double, quote_just_opened, close_pending;
  logic [7:0]    quoted_line_count;
  logic          cr_held;
  logic [31:0]   position_count;
  logic [9:0]    field_count;
  logic [31:0]   record_count;
  csvd_pkg::err_t error_latched;

  logic          quote_open_next, quote_is_double_next, quote_just_opened_next;
  logic          close_pending_next;
  logic [7:0]    quoted_line_count_next;
  logic          cr_held_next;
  logic [31:0]   position_count_next;
  logic [9:0]    field_count_next;
  logic [31:0]   record_count_next;
  csvd_pkg::err_t error_latched_next;

  // results of the current byte
  csvd_pkg::result_t cr_res, cur_res;
  logic              cr_v, cur_v;

  // result queue
  csvd_pkg::result_t                 queue [csvd_pkg::QDEPTH];
  logic [csvd_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [csvd_pkg::QCNT_W-1:0]       count, count_next;
  logic                              accept, pop;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_sep_a      <= 8'd44;
      value_sep_b      <= 8'd44;
      line_sep_a       <= 8'd10;
      line_sep_b       <= 8'd10;
      crlf_enable      <= 1'b1;
      max_quoted_lines <= 8'd2;
    end else if (cfg.valid) begin
      case (csvd_pkg::cfg_reg_t'(cfg.index))
        csvd_pkg::CFG_VALUE_SEP_A:      value_sep_a      <= cfg.data;
        csvd_pkg::CFG_VALUE_SEP_B:      value_sep_b      <= cfg.data;
        csvd_pkg::CFG_LINE_SEP_A:       line_sep_a       <= cfg.data;
        csvd_pkg::CFG_LINE_SEP_B:       line_sep_b       <= cfg.data;
        csvd_pkg::CFG_CRLF_ENABLE:      crlf_enable      <= cfg.data[0];
        csvd_pkg::CFG_MAX_QUOTED_LINES: max_quoted_lines <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshakes
  assign accept = text.valid && text.ready;
  assign pop    = tokens.valid && tokens.ready;
  assign text.ready = (count <= csvd_pkg::QCNT_W'(csvd_pkg::QDEPTH - 2));

  // byte classification and next text state
  always_comb begin
    logic [7:0] b;
    logic       eod, is_vs, is_ls, is_quote, done, qo, quoted_err;
    logic [7:0] qc;

    b        = text.in_byte;
    eod      = text.end_of_data;
    is_vs    = (b == value_sep_a) || (b == value_sep_b);
    is_ls    = (b == line_sep_a) || (b == line_sep_b);
    is_quote = (b == csvd_pkg::CH_DQ) || (b == csvd_pkg::CH_SQ);
    qc       = quote_is_double ? csvd_pkg::CH_DQ : csvd_pkg::CH_SQ;
    done       = 1'b0;
    qo         = quote_open;
    quoted_err = 1'b0;

    quote_open_next        = quote_open;
    quote_is_double_next   = quote_is_double;
    quote_just_opened_next = quote_just_opened;
    close_pending_next     = close_pending;
    quoted_line_count_next = quoted_line_count;
    cr_held_next           = cr_held;
    field_count_next       = field_count;
    record_count_next      = record_count;
    error_latched_next     = error_latched;
    position_count_next    = (position_count == csvd_pkg::COUNT_MAX) ?
                             position_count : position_count + 32'd1;

    // replayed carriage return
    cr_v                 = 1'b0;
    cr_res.kind          = csvd_pkg::KIND_CONTENT;
    cr_res.out_byte      = csvd_pkg::CH_CR;
    cr_res.byte_offset   = (position_count == 32'd0) ? 32'd0 : position_count - 32'd1;
    cr_res.field_number  = field_count;
    cr_res.record_number = record_count;
    cr_res.error_code    = csvd_pkg::ERR_NONE;
    cr_res.last          = 1'b0;

    // result of this byte
    cur_v                 = 1'b1;
    cur_res.kind          = csvd_pkg::KIND_CONTENT;
    cur_res.out_byte      = b;
    cur_res.byte_offset   = position_count;
    cur_res.field_number  = field_count;
    cur_res.record_number = record_count;
    cur_res.error_code    = csvd_pkg::ERR_NONE;
    cur_res.last          = eod;

    if (error_latched != csvd_pkg::ERR_NONE) begin
      cur_res.kind       = csvd_pkg::KIND_ERROR;
      cur_res.error_code = error_latched;
    end else begin
      // held cr is dropped only before a line feed that ends a line
      if (cr_held) begin
        cr_held_next = 1'b0;
        cr_v         = !((b == csvd_pkg::CH_LF) && is_ls);
      end

      // lookahead after a quote char inside a span
      if (close_pending) begin
        close_pending_next = 1'b0;
        if (b == qc) begin
          done = 1'b1;
        end else begin
          qo = 1'b0;
        end
      end
      quote_open_next = qo;

      if (!done && qo) begin
        // inside a quoted span
        quote_just_opened_next = 1'b0;
        if (b == qc) begin
          if (quote_just_opened) begin
            quote_open_next = 1'b0;
          end else begin
            close_pending_next = 1'b1;
          end
        end else if (is_ls) begin
          if (quoted_line_count == max_quoted_lines) begin
            quoted_err         = 1'b1;
            cur_res.kind       = csvd_pkg::KIND_ERROR;
            cur_res.error_code = csvd_pkg::ERR_QUOTED_LINES;
            error_latched_next = csvd_pkg::ERR_QUOTED_LINES;
          end else begin
            quoted_line_count_next = quoted_line_count + 8'd1;
          end
        end
      end else if (!done) begin
        // unquoted byte
        if (is_quote) begin
          quote_open_next        = 1'b1;
          quote_is_double_next   = (b == csvd_pkg::CH_DQ);
          quote_just_opened_next = 1'b1;
          quoted_line_count_next = 8'd0;
        end else if (is_vs) begin
          cur_res.kind = csvd_pkg::KIND_VALUE_SEP;
          if (field_count < csvd_pkg::FIELD_MAX) begin
            field_count_next = field_count + 10'd1;
          end
        end else if (is_ls) begin
          cur_res.kind     = csvd_pkg::KIND_LINE_SEP;
          field_count_next = 10'd0;
          if (record_count != csvd_pkg::COUNT_MAX) begin
            record_count_next = record_count + 32'd1;
          end
        end else if ((b == csvd_pkg::CH_CR) && crlf_enable && !eod) begin
          cr_held_next = 1'b1;
          cur_v        = 1'b0;
        end
      end

      // span still open at end of text
      if (eod && !quoted_err && quote_open_next && !close_pending_next) begin
        cur_res.kind       = csvd_pkg::KIND_ERROR;
        cur_res.error_code = csvd_pkg::ERR_UNTERMINATED;
        error_latched_next = csvd_pkg::ERR_UNTERMINATED;
      end
    end

    // end of text starts the next one from zero
    if (eod) begin
      quote_open_next        = 1'b0;
      quote_is_double_next   = 1'b0;
      quote_just_opened_next = 1'b0;
      close_pending_next     = 1'b0;
      quoted_line_count_next = 8'd0;
      cr_held_next           = 1'b0;
      position_count_next    = 32'd0;
      field_count_next       = 10'd0;
      record_count_next      = 32'd0;
    end
  end

  // text state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_open        <= 1'b0;
      quote_is_double   <= 1'b0;
      quote_just_opened <= 1'b0;
      close_pending     <= 1'b0;
      quoted_line_count <= 8'd0;
      cr_held           <= 1'b0;
      position_count    <= 32'd0;
      field_count       <= 10'd0;
      record_count      <= 32'd0;
      error_latched     <= csvd_pkg::ERR_NONE;
    end else if (accept) begin
      quote_open        <= quote_open_next;
      quote_is_double   <= quote_is_double_next;
      quote_just_opened <= quote_just_opened_next;
      close_pending     <= close_pending_next;
      quoted_line_count <= quoted_line_count_next;
      cr_held           <= cr_held_next;
      position_count    <= position_count_next;
      field_count       <= field_count_next;
      record_count      <= record_count_next;
      error_latched     <= error_latched_next;
    end
  end

  // result queue storage, up to two entries written per transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cr_v) begin
        queue[wr_ptr] <= cr_res;
        if (cur_v) begin
          queue[wr_ptr + csvd_pkg::QPTR_W'(1)] <= cur_res;
        end
      end else if (cur_v) begin
        queue[wr_ptr] <= cur_res;
      end
    end
  end

  // queue pointers and fill count
  always_comb begin
    logic [csvd_pkg::QCNT_W-1:0] n_in;
    n_in = accept ? (csvd_pkg::QCNT_W'(cr_v) + csvd_pkg::QCNT_W'(cur_v)) : '0;
    count_next = count + n_in - csvd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + csvd_pkg::QPTR_W'(cr_v) + csvd_pkg::QPTR_W'(cur_v);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + csvd_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // output channel
  assign tokens.valid         = (count != '0);
  assign tokens.kind          = queue[rd_ptr].kind;
  assign tokens.out_byte      = queue[rd_ptr].out_byte;
  assign tokens.byte_offset   = queue[rd_ptr].byte_offset;
  assign tokens.field_number  = queue[rd_ptr].field_number;
  assign tokens.record_number = queue[rd_ptr].record_number;
  assign tokens.error_code    = queue[rd_ptr].error_code;
  assign tokens.last          = queue[rd_ptr].last;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= csvd_pkg::QCNT_W'(csvd_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    text.ready |-> (count <= csvd_pkg::QCNT_W'(csvd_pkg::QDEPTH - 2)))
    else $error("byte taken without room for two results");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_latched != csvd_pkg::ERR_NONE) |=> $stable(error_latched))
    else $error("latched error changed");

  a_cr_unquoted: assert property (@(posedge clk) disable iff (rst)
    cr_held |-> (!quote_open && !close_pending))
    else $error("carriage return held inside a quoted span");

endmodule

>>> tb/csv_field_delimiter_tb.sv
// ----------------------------------------------------------------------------
// csv_field_delimiter_tb
// Streams csv text through the delimiter and checks every classified token
// against an in-bench prediction. Covers directed quoting and crlf cases,
// several separator settings under random idling, and a latched error at
// the end of the run.
// ----------------------------------------------------------------------------
module csv_field_delimiter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       eod;
  } text_byte_t;

  logic clk;
  logic rst;

  csvd_in_if  text_ch ();
  csvd_out_if token_ch ();
  csvd_cfg_if cfg_ch ();

  csv_field_delimiter dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (token_ch),
    .cfg    (cfg_ch)
  );

  // separator settings as the block should currently hold them
  logic [7:0] sep_val_a, sep_val_b, sep_line_a, sep_line_b;
  logic       crlf_on;
  logic [7:0] quoted_line_limit;

  // tokenizer state mirrored for prediction
  logic            span_open, quote_dq, quote_fresh, close_wait, cr_pending;
  logic [7:0]      quoted_lines;
  logic [31:0]     offset_count;
  logic [9:0]      field_idx;
  logic [31:0]     record_idx;
  csvd_pkg::err_t  latched_err;

  csvd_pkg::result_t expected_tokens[$];
  text_byte_t        staged_bytes[$];
  text_byte_t        pending_bytes[$];

  int    send_idle_pct;
  int    recv_stall_pct;
  int    failures;
  int    bytes_taken;
  int    tokens_checked;
  int    replayed_crs;
  int    texts_staged;
  string error_case;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_value_sep(logic [7:0] b);
    return (b == sep_val_a) || (b == sep_val_b);
  endfunction

  function automatic logic is_line_sep(logic [7:0] b);
    return (b == sep_line_a) || (b == sep_line_b);
  endfunction

  function automatic void add_token(csvd_pkg::kind_t k, logic [7:0] b, logic [31:0] off,
                                    csvd_pkg::err_t e, logic lst);
    csvd_pkg::result_t t;
    t.kind          = k;
    t.out_byte      = b;
    t.byte_offset   = off;
    t.field_number  = field_idx;
    t.record_number = record_idx;
    t.error_code    = e;
    t.last          = lst;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  // end of text: counters and quote state start over, errors stay
  function automatic void clear_text();
    span_open    = 1'b0;
    quote_dq     = 1'b0;
    quote_fresh  = 1'b0;
    close_wait   = 1'b0;
    quoted_lines = '0;
    cr_pending   = 1'b0;
    offset_count = '0;
    field_idx    = '0;
    record_idx   = '0;
  endfunction

  // tokens one accepted text byte should produce
  task automatic predict_byte(input logic [7:0] b, input logic eod);
    logic [31:0] p;
    logic [7:0]  qc;
    logic        handled;
    logic        fresh;
    p       = offset_count;
    handled = 1'b0;
    bytes_taken++;
    if (offset_count != csvd_pkg::COUNT_MAX) offset_count++;

    // latched error swallows everything
    if (latched_err != csvd_pkg::ERR_NONE) begin
      add_token(csvd_pkg::KIND_ERROR, b, p, latched_err, eod);
      if (eod) clear_text();
      return;
    end

    // held cr is dropped only before a line-feed separator
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (!(b == csvd_pkg::CH_LF && is_line_sep(b))) begin
        add_token(csvd_pkg::KIND_CONTENT, csvd_pkg::CH_CR, (p != 0) ? p - 32'd1 : 32'd0,
                  csvd_pkg::ERR_NONE, 1'b0);
        replayed_crs++;
      end
    end

    // a quote inside a span waits on the next byte: doubled means literal
    if (close_wait) begin
      close_wait = 1'b0;
      if (b == (quote_dq ? csvd_pkg::CH_DQ : csvd_pkg::CH_SQ)) handled = 1'b1;
      else span_open = 1'b0;
    end

    // inside a quoted span everything is content until the line limit is passed
    if (!handled && span_open) begin
      qc          = quote_dq ? csvd_pkg::CH_DQ : csvd_pkg::CH_SQ;
      fresh       = quote_fresh;
      quote_fresh = 1'b0;
      handled     = 1'b1;
      if (b == qc) begin
        if (fresh) span_open = 1'b0;
        else close_wait = 1'b1;
      end else if (is_line_sep(b)) begin
        if (quoted_lines == quoted_line_limit) begin
          latched_err = csvd_pkg::ERR_QUOTED_LINES;
          add_token(csvd_pkg::KIND_ERROR, b, p, csvd_pkg::ERR_QUOTED_LINES, eod);
          if (eod) clear_text();
          return;
        end
        quoted_lines = quoted_lines + 8'd1;
      end
    end

    // unquoted byte: quotes win over separators, value over line
    if (!handled) begin
      if (b == csvd_pkg::CH_DQ || b == csvd_pkg::CH_SQ) begin
        span_open    = 1'b1;
        quote_dq     = (b == csvd_pkg::CH_DQ);
        quote_fresh  = 1'b1;
        quoted_lines = '0;
      end else if (is_value_sep(b)) begin
        add_token(csvd_pkg::KIND_VALUE_SEP, b, p, csvd_pkg::ERR_NONE, eod);
        if (field_idx < csvd_pkg::FIELD_MAX) field_idx++;
        if (eod) clear_text();
        return;
      end else if (is_line_sep(b)) begin
        add_token(csvd_pkg::KIND_LINE_SEP, b, p, csvd_pkg::ERR_NONE, eod);
        field_idx = '0;
        if (record_idx != csvd_pkg::COUNT_MAX) record_idx++;
        if (eod) clear_text();
        return;
      end else if (b == csvd_pkg::CH_CR && crlf_on && !eod) begin
        cr_pending = 1'b1;
        return;
      end
    end

    // open span at end of text
    if (eod && span_open && !close_wait) begin
      latched_err = csvd_pkg::ERR_UNTERMINATED;
      add_token(csvd_pkg::KIND_ERROR, b, p, csvd_pkg::ERR_UNTERMINATED, 1'b1);
    end else begin
      add_token(csvd_pkg::KIND_CONTENT, b, p, csvd_pkg::ERR_NONE, eod);
    end
    if (eod) clear_text();
  endtask

  function automatic void stage_byte(logic [7:0] b, logic eod);
    text_byte_t t;
    t.value = b;
    t.eod   = eod;
    staged_bytes.insert(staged_bytes.size(), t);
  endfunction

  function automatic void hand_over_staged(int count);
    for (int i = 0; i < count; i++)
      pending_bytes.insert(pending_bytes.size(), staged_bytes.pop_front());
  endfunction

  // unquoted byte, leaning toward separators and cr/lf, never a quote
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    int         r;
    do begin
      r = $urandom_range(99);
      if (r < 10)      b = sep_val_a;
      else if (r < 16) b = sep_val_b;
      else if (r < 24) b = sep_line_a;
      else if (r < 28) b = sep_line_b;
      else if (r < 36) b = csvd_pkg::CH_CR;
      else if (r < 40) b = csvd_pkg::CH_LF;
      else             b = 8'($urandom_range(255));
    end while (b == csvd_pkg::CH_DQ || b == csvd_pkg::CH_SQ);
    return b;
  endfunction

  // byte inside a span; keeps line separators within the limit
  function automatic logic [7:0] pick_quoted(logic [7:0] qc, logic first, int lines);
    logic [7:0] b;
    int         r;
    do begin
      r = $urandom_range(99);
      if (r < 8)       b = sep_line_a;
      else if (r < 15) b = sep_line_b;
      else if (r < 25) b = qc;
      else if (r < 32) b = sep_val_a;
      else if (r < 38) b = csvd_pkg::CH_CR;
      else             b = 8'($urandom_range(255));
    end while ((first && b == qc) ||
               (b != qc && is_line_sep(b) && lines >= quoted_line_limit));
    return b;
  endfunction

  // one well-formed text: plain runs and quoted spans, last byte flagged
  function automatic void stage_text();
    int         pieces;
    int         len;
    int         lines;
    logic [7:0] qc;
    logic [7:0] b;
    pieces = $urandom_range(1, 8);
    for (int i = 0; i < pieces; i++) begin
      if ($urandom_range(99) < 40) begin
        qc = $urandom_range(1) ? csvd_pkg::CH_DQ : csvd_pkg::CH_SQ;
        stage_byte(qc, 1'b0);
        if ($urandom_range(5) == 0) begin
          stage_byte(qc, 1'b0);
        end else begin
          len   = $urandom_range(1, 6);
          lines = 0;
          for (int j = 0; j < len; j++) begin
            b = pick_quoted(qc, j == 0, lines);
            stage_byte(b, 1'b0);
            if (b == qc) stage_byte(qc, 1'b0);
            else if (is_line_sep(b)) lines++;
          end
          stage_byte(qc, 1'b0);
        end
        // must not be the quote again or the span would stay open
        stage_byte(pick_plain(), 1'b0);
      end else begin
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) stage_byte(pick_plain(), 1'b0);
      end
    end
    stage_byte(pick_plain(), 1'b1);
    texts_staged++;
  endfunction

  // text driver: prediction happens on each accepted transfer
  always @(posedge clk) begin
    text_byte_t t;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) predict_byte(text_ch.in_byte, text_ch.end_of_data);
      if (!text_ch.valid || text_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          t = pending_bytes.pop_front();
          text_ch.valid       <= 1'b1;
          text_ch.in_byte     <= t.value;
          text_ch.end_of_data <= t.eod;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  // token monitor with random backpressure
  always @(posedge clk) begin
    csvd_pkg::result_t t;
    if (rst) begin
      token_ch.ready <= 1'b0;
    end else begin
      if (token_ch.valid && token_ch.ready) begin
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
          failures++;
          $error("token transfer with nothing expected: kind %0d byte 0x%0h offset %0d",
                 token_ch.kind, token_ch.out_byte, token_ch.byte_offset);
        end else begin
          t = expected_tokens.pop_front();
          report_field("kind", t.kind, token_ch.kind);
          report_field("out_byte", t.out_byte, token_ch.out_byte);
          report_field("byte_offset", t.byte_offset, token_ch.byte_offset);
          report_field("field_number", t.field_number, token_ch.field_number);
          report_field("record_number", t.record_number, token_ch.record_number);
          report_field("error_code", t.error_code, token_ch.error_code);
          report_field("last", t.last, token_ch.last);
        end
      end
      token_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(csvd_pkg::cfg_reg_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      csvd_pkg::CFG_VALUE_SEP_A:      sep_val_a = value;
      csvd_pkg::CFG_VALUE_SEP_B:      sep_val_b = value;
      csvd_pkg::CFG_LINE_SEP_A:       sep_line_a = value;
      csvd_pkg::CFG_LINE_SEP_B:       sep_line_b = value;
      csvd_pkg::CFG_CRLF_ENABLE:      crlf_on = value[0];
      csvd_pkg::CFG_MAX_QUOTED_LINES: quoted_line_limit = value;
      default: ;
    endcase
  endtask

  // all bytes taken, all tokens back, then room for a held cr to settle
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || text_ch.valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic [7:0] vsa, logic [7:0] vsb,
                           logic [7:0] lsa, logic [7:0] lsb, logic crlf, logic [7:0] maxq,
                           logic pause_midway);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(csvd_pkg::CFG_VALUE_SEP_A, vsa);
    write_reg(csvd_pkg::CFG_VALUE_SEP_B, vsb);
    write_reg(csvd_pkg::CFG_LINE_SEP_A, lsa);
    write_reg(csvd_pkg::CFG_LINE_SEP_B, lsb);
    write_reg(csvd_pkg::CFG_CRLF_ENABLE, {7'd0, crlf});
    write_reg(csvd_pkg::CFG_MAX_QUOTED_LINES, maxq);
    while (staged_bytes.size() < 170) stage_text();
    // sender holds mid-text until every token is back
    if (pause_midway) begin
      hand_over_staged(staged_bytes.size() / 2);
      wait_idle();
    end
    hand_over_staged(staged_bytes.size());
    wait_idle();
  endtask

  // stimulus
  initial begin
    logic [7:0] opening_text [25];
    rst                 = 1'b1;
    text_ch.valid       = 1'b0;
    text_ch.in_byte     = '0;
    text_ch.end_of_data = 1'b0;
    token_ch.ready      = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = csvd_pkg::CFG_VALUE_SEP_A;
    cfg_ch.data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    failures            = 0;
    bytes_taken         = 0;
    tokens_checked      = 0;
    replayed_crs        = 0;
    texts_staged        = 0;
    error_case          = "none";
    sep_val_a           = 8'd44;
    sep_val_b           = 8'd44;
    sep_line_a          = 8'd10;
    sep_line_b          = 8'd10;
    crlf_on             = 1'b1;
    quoted_line_limit   = 8'd2;
    latched_err         = csvd_pkg::ERR_NONE;
    clear_text();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, empty quote, quoted separators, doubled
    // quote, crlf drop, cr replay, cr on last byte, close at end of text
    opening_text = '{8'h61, 8'h00, 8'hFF, 8'h2C, csvd_pkg::CH_DQ, csvd_pkg::CH_DQ,
                     csvd_pkg::CH_DQ, 8'h78, 8'h2C, csvd_pkg::CH_LF, csvd_pkg::CH_DQ,
                     csvd_pkg::CH_DQ, csvd_pkg::CH_DQ, 8'h79, csvd_pkg::CH_CR,
                     csvd_pkg::CH_LF, csvd_pkg::CH_SQ, csvd_pkg::CH_DQ, csvd_pkg::CH_SQ,
                     csvd_pkg::CH_CR, 8'h7A, csvd_pkg::CH_CR, csvd_pkg::CH_SQ, 8'h6B,
                     csvd_pkg::CH_SQ};
    for (int i = 0; i < 25; i++) stage_byte(opening_text[i], i == 21 || i == 24);

    // random texts on the reset settings
    while (staged_bytes.size() < 170) stage_text();
    hand_over_staged(staged_bytes.size());
    wait_idle();

    // separator settings, extremes included, under each idling mix
    run_phase(50, 0, 8'h3B, 8'h09, csvd_pkg::CH_LF, csvd_pkg::CH_CR, 1'b1, 8'd1, 1'b0);
    run_phase(0, 50, 8'h00, 8'hFF, 8'hFF, csvd_pkg::CH_CR, 1'b0, 8'd0, 1'b0);
    run_phase(8, 8, 8'h2C, csvd_pkg::CH_DQ, csvd_pkg::CH_SQ, csvd_pkg::CH_LF, 1'b1,
              8'hFF, 1'b0);
    run_phase(0, 0, 8'h2C, 8'h2C, 8'h1E, 8'h1E, 1'b1, 8'd3, 1'b1);

    // one error per run since only reset clears it; the seed picks which
    if ($urandom_range(1)) begin
      error_case = "quoted line limit";
      stage_byte(csvd_pkg::CH_DQ, 1'b0);
      for (int i = 0; i <= quoted_line_limit; i++) stage_byte(sep_line_a, 1'b0);
    end else begin
      error_case = "unterminated quote";
      stage_byte(csvd_pkg::CH_DQ, 1'b0);
      stage_byte(8'h41, 1'b0);
      stage_byte(8'h42, 1'b1);
    end
    // latched error on following texts
    for (int i = 0; i < 10; i++) stage_byte(8'($urandom_range(255)), i == 5 || i == 9);
    hand_over_staged(staged_bytes.size());
    wait_idle();

    $display("covered %0d bytes in %0d random texts plus directed text, %0d tokens checked",
             bytes_taken, texts_staged, tokens_checked);
    $display("%0d held carriage returns replayed, closing error case: %s",
             replayed_crs, error_case);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
